[hw/rtl/sco_pkg.sv]
`default_nettype none

package sco_pkg;

	localparam int TIME_W = 48;
	localparam int ID_W   = 16;
	localparam int KIND_W = 2;

	// default number of slot kinds: plain, openmp, mpi
	localparam int NUM_KINDS_DEF = 3;

	typedef struct packed {
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] end_time;
		logic [KIND_W-1:0] slot_kind;
		logic [ID_W-1:0]   location_id;
		logic [ID_W-1:0]   region_id;
		logic              flush;
	} item_t;

	typedef struct packed {
		logic [TIME_W-1:0] out_start;
		logic [TIME_W-1:0] out_end;
		logic [ID_W-1:0]   out_location;
		logic [ID_W-1:0]   out_region;
		logic              merged;
		logic              last_of_run;
	} result_t;

endpackage

`default_nettype wire

[hw/rtl/sco_group_core.sv]
`default_nettype none

module sco_group_core #(
	parameter int NUM_KINDS = sco_pkg::NUM_KINDS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire sco_pkg::item_t            item,
	input  wire logic [sco_pkg::TIME_W-1:0] min_duration,
	output logic [1:0]                     res_cnt,
	output sco_pkg::result_t               res0,
	output sco_pkg::result_t               res1
);

	localparam int TW = sco_pkg::TIME_W;
	localparam int IW = sco_pkg::ID_W;

	logic                 open_q;
	logic [TW-1:0]        gstart_q;
	logic [NUM_KINDS-1:0] present_q;
	logic [TW-1:0]        len_q  [NUM_KINDS];
	logic [IW-1:0]        loc_q  [NUM_KINDS];
	logic [IW-1:0]        rgn_q  [NUM_KINDS];
	logic [TW-1:0]        lend_q [NUM_KINDS];

	logic [TW-1:0]        dur;
	logic                 is_short;
	logic                 close_t;
	logic                 flush_close;
	logic [NUM_KINDS-1:0] sel;

	logic                 nxt_open;
	logic [TW-1:0]        nxt_gstart;
	logic [NUM_KINDS-1:0] nxt_present;
	logic [TW-1:0]        nxt_len  [NUM_KINDS];
	logic [IW-1:0]        nxt_loc  [NUM_KINDS];
	logic [IW-1:0]        nxt_rgn  [NUM_KINDS];
	logic [TW-1:0]        nxt_lend [NUM_KINDS];

	logic [TW-1:0]        og_end, ng_end;
	logic [IW-1:0]        og_loc, og_rgn, ng_loc, ng_rgn;

	sco_pkg::result_t     r_time, r_pass, r_flush;

	assign dur      = (item.end_time >= item.start_time) ?
	                  (item.end_time - item.start_time) : '0;
	assign is_short = dur < min_duration;
	assign close_t  = open_q && (item.start_time > gstart_q) &&
	                  ((item.start_time - gstart_q) > min_duration);

	// out-of-range kinds fold into the highest one
	always_comb begin
		for (int i = 0; i < NUM_KINDS; i++) begin
			if (i == NUM_KINDS - 1) begin
				sel[i] = int'(item.slot_kind) >= i;
			end else begin
				sel[i] = int'(item.slot_kind) == i;
			end
		end
	end

	// summary of the group as it stands, highest present kind wins
	always_comb begin
		og_end = gstart_q;
		og_loc = '0;
		og_rgn = '0;
		for (int i = 0; i < NUM_KINDS; i++) begin
			if (present_q[i]) begin
				og_end = lend_q[i];
				og_loc = loc_q[i];
				og_rgn = rgn_q[i];
			end
		end
	end

	// group state after a time close and after this item joins
	always_comb begin
		nxt_open    = open_q && !close_t;
		nxt_gstart  = gstart_q;
		nxt_present = present_q & {NUM_KINDS{!close_t}};
		for (int i = 0; i < NUM_KINDS; i++) begin
			nxt_len[i]  = len_q[i];
			nxt_loc[i]  = loc_q[i];
			nxt_rgn[i]  = rgn_q[i];
			nxt_lend[i] = lend_q[i];
		end
		if (is_short) begin
			if (!nxt_open) begin
				nxt_gstart = item.start_time;
			end
			nxt_open = 1'b1;
			for (int i = 0; i < NUM_KINDS; i++) begin
				if (sel[i]) begin
					if (!nxt_present[i]) begin
						nxt_present[i] = 1'b1;
						nxt_len[i]     = dur;
						nxt_loc[i]     = item.location_id;
						nxt_rgn[i]     = item.region_id;
						nxt_lend[i]    = item.end_time;
					end else begin
						if (dur > len_q[i]) begin
							nxt_len[i] = dur;
							nxt_loc[i] = item.location_id;
							nxt_rgn[i] = item.region_id;
						end
						if (item.end_time > lend_q[i]) begin
							nxt_lend[i] = item.end_time;
						end
					end
				end
			end
		end
	end

	always_comb begin
		ng_end = nxt_gstart;
		ng_loc = '0;
		ng_rgn = '0;
		for (int i = 0; i < NUM_KINDS; i++) begin
			if (nxt_present[i]) begin
				ng_end = nxt_lend[i];
				ng_loc = nxt_loc[i];
				ng_rgn = nxt_rgn[i];
			end
		end
	end

	assign flush_close = item.flush && nxt_open;

	always_comb begin
		r_time  = '{out_start: gstart_q, out_end: og_end, out_location: og_loc,
		            out_region: og_rgn, merged: 1'b1, last_of_run: 1'b0};
		r_pass  = '{out_start: item.start_time, out_end: item.end_time,
		            out_location: item.location_id, out_region: item.region_id,
		            merged: 1'b0, last_of_run: 1'b0};
		r_flush = '{out_start: nxt_gstart, out_end: ng_end, out_location: ng_loc,
		            out_region: ng_rgn, merged: 1'b1, last_of_run: 1'b0};
	end

	// order: time close, pass-through, flush close
	always_comb begin
		res_cnt = 2'd0;
		res0    = r_pass;
		res1    = r_pass;
		if (close_t) begin
			res0    = r_time;
			res_cnt = 2'd1;
		end
		if (!is_short) begin
			if (res_cnt == 2'd0) begin
				res0 = r_pass;
			end else begin
				res1 = r_pass;
			end
			res_cnt = res_cnt + 2'd1;
		end
		if (flush_close) begin
			if (res_cnt == 2'd0) begin
				res0 = r_flush;
			end else begin
				res1 = r_flush;
			end
			res_cnt = res_cnt + 2'd1;
		end
		if (res_cnt == 2'd1) begin
			res0.last_of_run = 1'b1;
		end
		if (res_cnt == 2'd2) begin
			res1.last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q    <= 1'b0;
			present_q <= '0;
		end else if (en) begin
			open_q    <= nxt_open && !flush_close;
			present_q <= flush_close ? '0 : nxt_present;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gstart_q <= nxt_gstart;
			for (int i = 0; i < NUM_KINDS; i++) begin
				len_q[i]  <= nxt_len[i];
				loc_q[i]  <= nxt_loc[i];
				rgn_q[i]  <= nxt_rgn[i];
				lend_q[i] <= nxt_lend[i];
			end
		end
	end

	a_no_three: assert property (@(posedge clk) disable iff (!arst_n)
		en |-> (res_cnt != 2'd3))
		else $error("more than two results for one item");

	a_flush_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(en && item.flush) |=> !open_q)
		else $error("group still open after flush");

	a_present_needs_open: assert property (@(posedge clk) disable iff (!arst_n)
		(present_q != '0) |-> open_q)
		else $error("kind present without open group");

endmodule

`default_nettype wire

[hw/rtl/sco_result_fifo.sv]
`default_nettype none

module sco_result_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [1:0]       push_cnt,
	input  wire sco_pkg::result_t push0,
	input  wire sco_pkg::result_t push1,
	output logic                  room2,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output sco_pkg::result_t      result_data
);

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	sco_pkg::result_t mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    count_q;
	logic             pop;

	assign result_valid = count_q != '0;
	assign result_data  = mem_q[rp_q];
	assign pop          = result_valid && !result_stall;
	// room for the worst case of two results, judged before this cycle's transfer
	assign room2        = count_q <= CW'(DEPTH - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + AW'(push_cnt);
			rp_q    <= rp_q + AW'(pop);
			count_q <= count_q + CW'(push_cnt) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wp_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wp_q + AW'(1)] <= push1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt != 2'd0) |-> (count_q <= CW'(DEPTH - 2)))
		else $error("result buffer pushed without room");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("result buffer count out of range");

	a_stalled_head_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(result_data)))
		else $error("stalled result changed");

endmodule

`default_nettype wire

[hw/rtl/short_interval_coalescer_unit.sv]
`default_nettype none

// channel   signals                                  direction  transfer when
// item      item_valid, item_stall, item_data        in         item_valid && !item_stall
// result    result_valid, result_stall, result_data  out        result_valid && !result_stall
// cfg       cfg_valid, cfg_ready, cfg_data           in         cfg_valid && cfg_ready
//
// one item per cycle unless the item register holds; an item's first result goes through
// the item register and the result buffer before it can transfer; an item gives up to two
// results (group closed by time, pass-through, group closed by flush), in that order
// the item register holds while the 4-entry result buffer has fewer than two free slots
// arst_n clears the open group, min_duration and both buffers; no clearing pass
// cfg_ready is always high

module short_interval_coalescer_unit #(
	parameter int NUM_KINDS = sco_pkg::NUM_KINDS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       item_valid,
	output logic                            item_stall,
	input  wire sco_pkg::item_t             item_data,
	output logic                            result_valid,
	input  wire logic                       result_stall,
	output sco_pkg::result_t                result_data,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [sco_pkg::TIME_W-1:0] cfg_data
);

	logic [sco_pkg::TIME_W-1:0] min_dur_q;
	logic                       v_s1;
	sco_pkg::item_t             item_s1;
	logic                       room2;
	logic                       proc;
	logic                       accept;
	logic [1:0]                 res_cnt;
	logic [1:0]                 push_cnt;
	sco_pkg::result_t           res0, res1;

	assign cfg_ready  = 1'b1;
	assign proc       = v_s1 && room2;
	assign item_stall = v_s1 && !room2;
	assign accept     = item_valid && !item_stall;
	assign push_cnt   = proc ? res_cnt : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dur_q <= '0;
			v_s1      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				min_dur_q <= cfg_data;
			end
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (proc) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_data;
		end
	end

	sco_group_core #(
		.NUM_KINDS(NUM_KINDS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (proc),
		.item        (item_s1),
		.min_duration(min_dur_q),
		.res_cnt     (res_cnt),
		.res0        (res0),
		.res1        (res1)
	);

	sco_result_fifo u_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.push_cnt    (push_cnt),
		.push0       (res0),
		.push1       (res1),
		.room2       (room2),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data (result_data)
	);

	a_stall_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (v_s1 && !room2))
		else $error("item stalled with free stage");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted item lost from stage");

	a_held_item: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !proc) |=> (v_s1 && $stable(item_s1)))
		else $error("waiting item changed");

endmodule

`default_nettype wire

[bench/short_interval_coalescer_unit_tb.sv]
module short_interval_coalescer_unit_tb;

	localparam int TW = sco_pkg::TIME_W;
	localparam int IW = sco_pkg::ID_W;
	localparam int KW = sco_pkg::KIND_W;

	typedef enum logic [KW-1:0] {
		KIND_PLAIN,
		KIND_OPENMP,
		KIND_MPI,
		KIND_BEYOND
	} slot_kind_e;

	localparam int KINDS = sco_pkg::NUM_KINDS_DEF;
	localparam logic [63:0] TIME_MAX = (64'd1 << TW) - 1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 150;
	localparam int PHASE_ITEMS = 105;
	localparam int SWEEP_PHASES = 8;
	localparam int PRESSURE_PHASE = 3;
	localparam int PAUSE_PHASE = 5;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	sco_pkg::item_t item_data = '0;
	logic result_stall = 1'b0;
	logic cfg_valid = 1'b0;
	logic [TW-1:0] cfg_data = '0;
	logic item_stall;
	logic result_valid;
	sco_pkg::result_t result_data;
	logic cfg_ready;

	short_interval_coalescer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item_data(item_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data(result_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// coalescer state as the predictor sees it
	logic [TW-1:0] min_dur;
	logic          grp_open;
	logic [TW-1:0] grp_start;
	logic          kind_seen [KINDS];
	logic [TW-1:0] kind_len [KINDS];
	logic [IW-1:0] kind_loc [KINDS];
	logic [IW-1:0] kind_rgn [KINDS];
	logic [TW-1:0] kind_end [KINDS];

	sco_pkg::item_t   interval_queue [$];
	sco_pkg::result_t expected_emits [$];

	int error_count = 0;
	int cycle_count = 0;
	int tx_gap = 0;
	int rx_wait = 0;
	int hold_left = 0;
	int holds_asked = 0;
	int holds_served = 0;
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	logic [63:0] trace_now = 64'd1000;

	function automatic void queue_interval(input sco_pkg::item_t it);
		interval_queue = {interval_queue, it};
	endfunction

	function automatic void drop_group();
		grp_open = 1'b0;
		grp_start = '0;
		for (int k = 0; k < KINDS; k++) begin
			kind_seen[k] = 1'b0;
			kind_len[k] = '0;
			kind_loc[k] = '0;
			kind_rgn[k] = '0;
			kind_end[k] = '0;
		end
	endfunction

	// highest kind present decides end, location and region
	function automatic sco_pkg::result_t close_group();
		sco_pkg::result_t r;
		bit found;
		r = '0;
		found = 1'b0;
		r.out_start = grp_start;
		r.out_end = grp_start;
		r.merged = 1'b1;
		for (int k = KINDS - 1; k >= 0; k--) begin
			if (kind_seen[k] && !found) begin
				found = 1'b1;
				r.out_end = kind_end[k];
				r.out_location = kind_loc[k];
				r.out_region = kind_rgn[k];
			end
		end
		drop_group();
		return r;
	endfunction

	function automatic void coalesce_interval(input sco_pkg::item_t it);
		sco_pkg::result_t outs [$];
		sco_pkg::result_t r;
		logic [TW-1:0] dur;
		int k;
		if (grp_open && it.start_time > grp_start && (it.start_time - grp_start) > min_dur)
			outs = {outs, close_group()};
		dur = (it.end_time >= it.start_time) ? it.end_time - it.start_time : '0;
		if (dur < min_dur) begin
			k = (it.slot_kind >= KINDS) ? KINDS - 1 : int'(it.slot_kind);
			if (!grp_open) begin
				grp_open = 1'b1;
				grp_start = it.start_time;
			end
			if (!kind_seen[k]) begin
				kind_seen[k] = 1'b1;
				kind_len[k] = dur;
				kind_loc[k] = it.location_id;
				kind_rgn[k] = it.region_id;
				kind_end[k] = it.end_time;
			end else begin
				// strictly longer only, so the earliest member keeps a tie
				if (dur > kind_len[k]) begin
					kind_len[k] = dur;
					kind_loc[k] = it.location_id;
					kind_rgn[k] = it.region_id;
				end
				if (it.end_time > kind_end[k])
					kind_end[k] = it.end_time;
			end
		end else begin
			r = '0;
			r.out_start = it.start_time;
			r.out_end = it.end_time;
			r.out_location = it.location_id;
			r.out_region = it.region_id;
			outs = {outs, r};
		end
		if (it.flush && grp_open)
			outs = {outs, close_group()};
		if (outs.size() > 0)
			outs[outs.size() - 1].last_of_run = 1'b1;
		expected_emits = {expected_emits, outs};
	endfunction

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endtask

	task automatic check_result(input sco_pkg::result_t got);
		sco_pkg::result_t want;
		if (expected_emits.size() == 0) begin
			$error("result with nothing expected: out_start %0h out_end %0h",
				got.out_start, got.out_end);
			error_count++;
		end else begin
			want = expected_emits.pop_front();
			compare_field("out_start", 64'(want.out_start), 64'(got.out_start));
			compare_field("out_end", 64'(want.out_end), 64'(got.out_end));
			compare_field("out_location", 64'(want.out_location), 64'(got.out_location));
			compare_field("out_region", 64'(want.out_region), 64'(got.out_region));
			compare_field("merged", 64'(want.merged), 64'(got.merged));
			compare_field("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
		end
	endtask

	function automatic sco_pkg::item_t make_interval(input logic [63:0] st,
			input logic [63:0] en, input slot_kind_e kind, input logic [IW-1:0] loc,
			input logic [IW-1:0] rgn, input logic fl);
		sco_pkg::item_t it;
		it.start_time = st[TW-1:0];
		it.end_time = en[TW-1:0];
		it.slot_kind = kind;
		it.location_id = loc;
		it.region_id = rgn;
		it.flush = fl;
		return it;
	endfunction

	// mostly advancing trace time, with the odd jump or step back
	function automatic sco_pkg::item_t random_interval(input logic [63:0] md);
		logic [63:0] st;
		logic [63:0] en;
		logic [63:0] dur;
		logic [63:0] cap;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			trace_now = {$urandom, $urandom} & TIME_MAX;
		else if (pick < 7)
			trace_now = (trace_now > 64'd20) ?
				trace_now - 64'($urandom_range(1, 20)) : trace_now;
		else begin
			cap = (md > 64'd1200) ? 64'd400 : md / 3 + 2;
			trace_now = trace_now + 64'($urandom_range(0, int'(cap)));
			if (trace_now > TIME_MAX)
				trace_now = TIME_MAX;
		end
		st = trace_now;
		pick = $urandom_range(0, 99);
		if (pick < 50 && md != 0)
			dur = 64'($urandom_range(0, (md > 64'd31) ? 30 : int'(md - 1)));
		else if (pick < 60)
			dur = md;
		else if (pick < 92)
			dur = md + 64'($urandom_range(1, 50));
		else
			dur = 0;
		en = st + dur;
		if (en > TIME_MAX)
			en = TIME_MAX;
		if (pick >= 92 && st >= 64'd10)
			en = st - 64'($urandom_range(1, 10));
		return make_interval(st, en, slot_kind_e'($urandom_range(0, 3)),
			IW'($urandom), IW'($urandom), $urandom_range(0, 24) == 0);
	endfunction

	task automatic write_min_duration(input logic [63:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value[TW-1:0];
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		min_dur = value[TW-1:0];
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (interval_queue.size() != 0 || item_valid || expected_emits.size() != 0);
		// an item that emits nothing may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// sender
	always @(posedge clk) begin
		logic took;
		took = item_valid && !item_stall;
		if (took) begin
			coalesce_interval(item_data);
			void'(interval_queue.pop_front());
		end
		if (!item_valid || took) begin
			if (took && tx_idle)
				tx_gap = $urandom_range(0, 7);
			if (tx_gap == 0 && interval_queue.size() > 0) begin
				item_valid <= 1'b1;
				item_data <= interval_queue[0];
			end else begin
				item_valid <= 1'b0;
				if (tx_gap > 0)
					tx_gap--;
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_left > 0)
			hold_left <= hold_left - 1;
		else if (holds_served != holds_asked) begin
			hold_left <= HOLD_CYCLES;
			holds_served <= holds_served + 1;
		end
	end

	// receiver
	always @(posedge clk) begin
		if (result_valid && !result_stall) begin
			check_result(result_data);
			if (rx_idle)
				rx_wait = $urandom_range(0, 7);
		end else if (rx_wait > 0)
			rx_wait--;
		result_stall <= (rx_wait > 0) || (hold_left > 0);
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		logic [63:0] sweep [SWEEP_PHASES];
		min_dur = '0;
		drop_group();
		sweep[0] = 64'd0;
		sweep[1] = 64'd1;
		sweep[2] = 64'd7;
		sweep[3] = 64'd50;
		sweep[4] = 64'd1000;
		sweep[5] = {$urandom, $urandom} & TIME_MAX;
		sweep[6] = TIME_MAX;
		sweep[7] = 64'd12;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// zero threshold out of reset: every transfer passes through
		queue_interval(make_interval(0, 0, KIND_PLAIN, 16'h0000, 16'h0000, 1'b0));
		queue_interval(make_interval(TIME_MAX, TIME_MAX, KIND_MPI,
			16'hffff, 16'hffff, 1'b0));
		queue_interval(make_interval(50, 20, KIND_OPENMP, 16'h1234, 16'h5678, 1'b0));
		queue_interval(make_interval(60, 70, KIND_BEYOND, 16'h00aa, 16'h0055, 1'b0));
		queue_interval(make_interval(70, 71, KIND_PLAIN, 16'h0001, 16'h0002, 1'b1));
		wait_idle();

		write_min_duration(64'd10);
		// group from 100: tie on length, kind priority, out-of-range kind,
		// start behind the group start, end before start
		queue_interval(make_interval(100, 103, KIND_PLAIN, 16'd1, 16'd11, 1'b0));
		queue_interval(make_interval(102, 105, KIND_PLAIN, 16'd2, 16'd12, 1'b0));
		queue_interval(make_interval(104, 108, KIND_OPENMP, 16'd3, 16'd13, 1'b0));
		queue_interval(make_interval(105, 106, KIND_BEYOND, 16'd4, 16'd14, 1'b0));
		queue_interval(make_interval(99, 99, KIND_MPI, 16'd5, 16'd15, 1'b0));
		queue_interval(make_interval(103, 101, KIND_OPENMP, 16'd6, 16'd16, 1'b0));
		// leaves the window and passes through at exactly the threshold
		queue_interval(make_interval(111, 121, KIND_PLAIN, 16'd7, 16'd17, 1'b0));
		queue_interval(make_interval(112, 113, KIND_PLAIN, 16'd8, 16'd18, 1'b1));
		queue_interval(make_interval(120, 140, KIND_PLAIN, 16'd9, 16'd19, 1'b1));
		// closed by time, then a new group closed by the flush
		queue_interval(make_interval(130, 131, KIND_OPENMP, 16'd10, 16'd20, 1'b0));
		queue_interval(make_interval(141, 141, KIND_PLAIN, 16'd11, 16'd21, 1'b1));
		// window edge not crossed; pass-through then flushed group
		queue_interval(make_interval(150, 152, KIND_PLAIN, 16'd12, 16'd22, 1'b0));
		queue_interval(make_interval(160, 170, KIND_MPI, 16'd13, 16'd23, 1'b1));
		wait_idle();

		write_min_duration(TIME_MAX);
		queue_interval(make_interval(0, TIME_MAX, KIND_PLAIN, 16'd30, 16'd31, 1'b0));
		queue_interval(make_interval(10, 20, KIND_OPENMP, 16'd32, 16'd33, 1'b0));
		queue_interval(make_interval(TIME_MAX, TIME_MAX, KIND_MPI,
			16'd34, 16'd35, 1'b1));
		wait_idle();

		for (int p = 0; p < SWEEP_PHASES; p++) begin
			write_min_duration(sweep[p]);
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			if (p == PRESSURE_PHASE) begin
				// back-to-back transfers into a receiver that holds off
				tx_idle = 1'b0;
				rx_idle = 1'b0;
				for (int i = 0; i < PHASE_ITEMS; i++)
					queue_interval(random_interval(sweep[p]));
				repeat (20) @(posedge clk);
				holds_asked++;
			end else if (p == PAUSE_PHASE) begin
				for (int i = 0; i < PHASE_ITEMS / 2; i++)
					queue_interval(random_interval(sweep[p]));
				wait_idle();
				for (int i = PHASE_ITEMS / 2; i < PHASE_ITEMS; i++)
					queue_interval(random_interval(sweep[p]));
			end else begin
				for (int i = 0; i < PHASE_ITEMS; i++)
					queue_interval(random_interval(sweep[p]));
			end
			wait_idle();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
